// File: rtl/tgi_pkg.sv
// Package for the trilinear grid interpolator: widths, fixed-point constants,
// request codes and configuration register indexes. No dependencies.
`default_nettype none
package tgi_pkg;

  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 15;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int PADDR_W     = 5;
  localparam int IDX_W       = 8;
  localparam int NUM_CORNERS = 8;

  localparam int GRID_X_DEF   = 16;
  localparam int GRID_Y_DEF   = 16;
  localparam int GRID_Z_DEF   = 16;
  localparam int MAX_VARS_DEF = 8;

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [15:0] HALF_Q16 = 16'h8000;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_INV_X    = 3'd3;
  localparam logic [2:0] REG_INV_Y    = 3'd4;
  localparam logic [2:0] REG_INV_Z    = 3'd5;
  localparam logic [2:0] REG_NUM_VARS = 3'd6;

endpackage
`default_nettype wire

// File: rtl/tgi_if.sv
// Request and result channel interfaces of the trilinear grid interpolator.
// Depends on tgi_pkg for field widths.
`default_nettype none
interface tgi_req_if;
  import tgi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [DATA_W-1:0]  pos_x;
  logic signed [DATA_W-1:0]  pos_y;
  logic signed [DATA_W-1:0]  pos_z;
  logic        [ADDR_W-1:0]  load_address;
  logic signed [DATA_W-1:0]  load_value;
  modport source (output valid, req_type, pos_x, pos_y, pos_z, load_address, load_value,
                  input ready);
  modport sink (input valid, req_type, pos_x, pos_y, pos_z, load_address, load_value,
                output ready);
endinterface

interface tgi_res_if;
  import tgi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] interp_value;
  logic        [2:0]        var_index;
  logic                     found;
  logic                     last;
  modport source (output valid, interp_value, var_index, found, last, input ready);
  modport sink (input valid, interp_value, var_index, found, last, output ready);
endinterface
`default_nettype wire

// File: rtl/trilinear_grid_interpolator_unit.sv
// Top level of the trilinear grid interpolator: grid store, APB registers and
// the sequencer around one shared multiplier. Depends on tgi_pkg and tgi_if.
//
// A load request writes one store word. A query runs subtract, multiply and
// range check for each axis, forms the eight weights corner by corner, then
// does a store read, multiply and accumulate per corner and variable, and
// presents one result per variable, held until taken. An out-of-domain query
// ends early with one result.
// Every product goes through the single 34x34 multiplier; the block takes no
// request until the last result is taken.
`default_nettype none
module trilinear_grid_interpolator_unit #(
  parameter int GRID_X   = tgi_pkg::GRID_X_DEF,
  parameter int GRID_Y   = tgi_pkg::GRID_Y_DEF,
  parameter int GRID_Z   = tgi_pkg::GRID_Z_DEF,
  parameter int MAX_VARS = tgi_pkg::MAX_VARS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  tgi_req_if.sink                          req,
  tgi_res_if.source                        res,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tgi_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import tgi_pkg::*;

  localparam int MAX_NV = (MAX_VARS < 8) ? MAX_VARS : 8;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SUB   = 11'b00000000010,
    S_AXMUL = 11'b00000000100,
    S_AXRES = 11'b00000001000,
    S_W1    = 11'b00000010000,
    S_W2    = 11'b00000100000,
    S_W3    = 11'b00001000000,
    S_RD    = 11'b00010000000,
    S_MUL   = 11'b00100000000,
    S_ACC   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic signed [DATA_W-1:0] origin [3];
  logic        [DATA_W-1:0] inv_sp [3];
  logic        [3:0]        num_vars;

  // Store
  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;

  // Query state
  logic signed [DATA_W-1:0] pos_q [3];
  logic [1:0]               axis;
  logic signed [DATA_W:0]   d_q;
  logic [IDX_W-1:0]         lo [3];
  logic [IDX_W-1:0]         hi [3];
  logic [15:0]              frac [3];
  logic [2:0]               corner;
  logic [DATA_W:0]          wgt [NUM_CORNERS];
  logic [ADDR_W-1:0]        cell_addr [NUM_CORNERS];
  logic [2:0]               var_cnt;
  logic [3:0]               nv;
  logic signed [63:0]       acc;
  logic signed [63:0]       acc_sum;

  // Output register
  logic signed [DATA_W-1:0] out_value;
  logic [2:0]               out_var;
  logic                     out_found;
  logic                     out_last;

  // Shared multiplier
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] mul_p;

  logic [8:0]         grid_n;
  logic [65:0]        u;
  logic [65:0]        u_lim;
  logic signed [25:0] t;
  logic signed [9:0]  cell_i;
  logic signed [9:0]  cell_lim;
  logic [16:0]        ax, ay, az;
  logic [IDX_W-1:0]   cx, cy, cz;
  logic [31:0]        lin;
  logic [18:0]        addr_prod;
  logic               cfg_wr;

  function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [9:0] c,
                                                 input logic signed [9:0] lim);
    logic [IDX_W-1:0] r;
    if (c < 0) begin
      r = '0;
    end else if (c > lim) begin
      r = IDX_W'(lim);
    end else begin
      r = IDX_W'(c);
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[4:2])
      REG_ORIGIN_X: prdata = origin[0];
      REG_ORIGIN_Y: prdata = origin[1];
      REG_ORIGIN_Z: prdata = origin[2];
      REG_INV_X:    prdata = inv_sp[0];
      REG_INV_Y:    prdata = inv_sp[1];
      REG_INV_Z:    prdata = inv_sp[2];
      REG_NUM_VARS: prdata = {28'd0, num_vars};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0;
      origin[1] <= '0;
      origin[2] <= '0;
      inv_sp[0] <= 32'h0001_0000;
      inv_sp[1] <= 32'h0001_0000;
      inv_sp[2] <= 32'h0001_0000;
      num_vars  <= 4'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_ORIGIN_X: origin[0] <= pwdata;
        REG_ORIGIN_Y: origin[1] <= pwdata;
        REG_ORIGIN_Z: origin[2] <= pwdata;
        REG_INV_X:    inv_sp[0] <= pwdata;
        REG_INV_Y:    inv_sp[1] <= pwdata;
        REG_INV_Z:    inv_sp[2] <= pwdata;
        REG_NUM_VARS: num_vars  <= pwdata[3:0];
        default:      ;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);

  assign res.valid        = (state == S_OUT);
  assign res.interp_value = out_value;
  assign res.var_index    = out_var;
  assign res.found        = out_found;
  assign res.last         = out_last;

  always_comb begin
    unique case (axis)
      2'd0:    grid_n = 9'(GRID_X);
      2'd1:    grid_n = 9'(GRID_Y);
      default: grid_n = 9'(GRID_Z);
    endcase
  end

  // Axis mapping: t = (u >> 16) - 0.5; the cell is t >> 16, the fraction t's low half.
  // The range check bounds u to GRID << 32, so u[40:16] holds all of u >> 16.
  assign u        = mul_p[65:0];
  assign u_lim    = {25'd0, grid_n, 32'd0};
  assign t        = $signed({1'b0, u[40:16]}) - $signed({10'd0, HALF_Q16});
  assign cell_i   = t[25:16];
  assign cell_lim = $signed({1'b0, grid_n}) - 10'sd1;

  assign ax = corner[0] ? {1'b0, frac[0]} : ONE_Q16 - {1'b0, frac[0]};
  assign ay = corner[1] ? {1'b0, frac[1]} : ONE_Q16 - {1'b0, frac[1]};
  assign az = corner[2] ? {1'b0, frac[2]} : ONE_Q16 - {1'b0, frac[2]};
  assign cx = corner[0] ? hi[0] : lo[0];
  assign cy = corner[1] ? hi[1] : lo[1];
  assign cz = corner[2] ? hi[2] : lo[2];
  assign lin = 32'(cx) + 32'(GRID_X) * (32'(cy) + 32'(GRID_Y) * 32'(cz));

  // Only the low address bits matter, since the store address wraps.
  assign addr_prod = 19'(nv) * 19'(cell_addr[corner]);
  assign rd_addr   = ADDR_W'(addr_prod) + ADDR_W'(var_cnt);
  assign acc_sum   = acc + mul_p[63:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_AXMUL: begin
        mul_a = {1'b0, d_q};
        mul_b = {2'b00, inv_sp[axis]};
      end
      S_W1: begin
        mul_a = {17'd0, ax};
        mul_b = {17'd0, ay};
      end
      S_W2: begin
        mul_a = mul_p[33:0];
        mul_b = {17'd0, az};
      end
      S_MUL: begin
        mul_a = {{2{rd_data[DATA_W-1]}}, rd_data};
        mul_b = {1'b0, wgt[corner]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (state == S_RD) begin
      rd_data <= mem[rd_addr];
    end
    if (req.valid && req.ready && req.req_type == REQ_LOAD) begin
      mem[req.load_address] <= req.load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.req_type == REQ_QUERY) begin
            pos_q[0] <= req.pos_x;
            pos_q[1] <= req.pos_y;
            pos_q[2] <= req.pos_z;
            axis     <= 2'd0;
            if (num_vars == 4'd0) begin
              nv <= 4'd1;
            end else if (num_vars > 4'(MAX_NV)) begin
              nv <= 4'(MAX_NV);
            end else begin
              nv <= num_vars;
            end
            state <= S_SUB;
          end
        end
        S_SUB: begin
          d_q   <= {pos_q[axis][DATA_W-1], pos_q[axis]} - {origin[axis][DATA_W-1], origin[axis]};
          state <= S_AXMUL;
        end
        S_AXMUL: begin
          if (d_q[DATA_W]) begin
            out_value <= '0;
            out_var   <= '0;
            out_found <= 1'b0;
            out_last  <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= S_AXRES;
          end
        end
        S_AXRES: begin
          if (u > u_lim) begin
            out_value <= '0;
            out_var   <= '0;
            out_found <= 1'b0;
            out_last  <= 1'b1;
            state     <= S_OUT;
          end else begin
            lo[axis]   <= clamp_idx(cell_i, cell_lim);
            hi[axis]   <= clamp_idx(cell_i + 10'sd1, cell_lim);
            frac[axis] <= t[15:0];
            if (axis == 2'd2) begin
              corner <= '0;
              state  <= S_W1;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_SUB;
            end
          end
        end
        S_W1: state <= S_W2;
        S_W2: state <= S_W3;
        S_W3: begin
          wgt[corner]       <= mul_p[48:16];
          cell_addr[corner] <= lin[ADDR_W-1:0];
          corner            <= corner + 3'd1;
          if (corner == 3'd7) begin
            var_cnt <= '0;
            acc     <= '0;
            state   <= S_RD;
          end else begin
            state <= S_W1;
          end
        end
        S_RD:  state <= S_MUL;
        S_MUL: state <= S_ACC;
        S_ACC: begin
          acc    <= acc_sum;
          corner <= corner + 3'd1;
          if (corner == 3'd7) begin
            out_value <= acc_sum[63:32];
            out_var   <= var_cnt;
            out_found <= 1'b1;
            out_last  <= ({1'b0, var_cnt} == nv - 4'd1);
            state     <= S_OUT;
          end else begin
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (res.ready) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              var_cnt <= var_cnt + 3'd1;
              acc     <= '0;
              corner  <= '0;
              state   <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
